>>> rtl/cyg_pkg.sv
// ----------------------------------------------------------------------------
// cyg_pkg
// shared types and elaboration-time helpers for the Yxy to gamma RGB converter
// ----------------------------------------------------------------------------
`default_nettype none

package cyg_pkg;

  typedef struct packed {
    logic [13:0] lum_y;
    logic [13:0] chroma_x;
    logic [13:0] chroma_y;
  } cyg_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bad_chroma;
  } cyg_out_t;

  typedef struct packed {
    logic vld;
    logic kill;
    logic bad;
  } cyg_side_t;

  typedef struct packed {
    cyg_side_t side;
    logic      pos;
    logic      sat;
  } cyg_tag_t;

  localparam int MatNum [9] = '{4674, -2126, -726, -2589, 5011, 111, 183, -617, 2883};
  localparam int MatDen [3] = '{426, 858, 984};
  localparam int unsigned WhiteSum = 10000;
  localparam logic [7:0] DarkCode = 8'd7;

  // largest k with (k/255)^(11/5) <= idx/2^gb, exact
  function automatic logic [7:0] gamma_val(int unsigned idx, int unsigned gb);
    logic [191:0] lhs;
    logic [191:0] rhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    lhs = 192'd1;
    for (int j = 0; j < 5; j++) lhs = lhs * 192'(idx);
    for (int j = 0; j < 11; j++) lhs = lhs * 192'd255;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      rhs = 192'd1;
      for (int j = 0; j < 11; j++) rhs = rhs * 192'(mid);
      rhs = rhs << (5 * gb);
      if (rhs <= lhs) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cie_yxy_to_rgb_gamma.sv
// ----------------------------------------------------------------------------
// cie_yxy_to_rgb_gamma
// Yxy colour to gamma 2.2 corrected 8-bit RGB, fully pipelined
//
//   channel  | handshake      | word
//   ---------+----------------+-------------------------------
//   input    | start / busy   | in_word_i  (lum_y, x, y)
//   result   | done_o strobe  | out_word_o (r, g, b, flag)
//
// one word enters per cycle; the divider resolves one quotient bit per stage
// busy is never raised; reset clears only the control bits (valid, kill, bad, pos, sat) of the pipeline
// the receiver cannot stall, so nothing in the pipe ever waits
// ----------------------------------------------------------------------------
`default_nettype none

module cie_yxy_to_rgb_gamma #(
  parameter int FRAC_BITS      = 16,
  parameter int GAMMA_LUT_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cyg_pkg::cyg_in_t  in_word_i,
  output logic              done_o,
  output cyg_pkg::cyg_out_t out_word_o
);
  import cyg_pkg::*;

  cyg_side_t          in_side_q;
  logic [13:0]        lum_q, cx_q, cy_q;
  logic signed [15:0] w_q;
  cyg_side_t          side_r, side_g, side_b;
  logic [7:0]         gam_r, gam_g, gam_b;
  logic               dark;
  logic               done_q;
  cyg_out_t           out_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_side_q <= '0;
      done_q    <= 1'b0;
    end else begin
      in_side_q <= '{vld:  start && !busy,
                     kill: (in_word_i.chroma_y == '0),
                     bad:  (in_word_i.chroma_y == '0) && (in_word_i.lum_y != '0)};
      done_q    <= side_r.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    lum_q <= in_word_i.lum_y;
    cx_q  <= in_word_i.chroma_x;
    cy_q  <= in_word_i.chroma_y;
    w_q   <= 16'(WhiteSum) - $signed({2'b00, in_word_i.chroma_x})
                           - $signed({2'b00, in_word_i.chroma_y});
    out_q <= '{red:        dark ? DarkCode : gam_r,
               green:      dark ? DarkCode : gam_g,
               blue:       dark ? DarkCode : gam_b,
               bad_chroma: side_r.bad};
  end

  assign dark = (gam_r == '0) && (gam_g == '0) && (gam_b == '0);

  cyg_chan #(.F(FRAC_BITS), .G(GAMMA_LUT_BITS), .ROW(0)) u_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (in_side_q),
    .lum_i  (lum_q),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .w_i    (w_q),
    .side_o (side_r),
    .gam_o  (gam_r)
  );

  cyg_chan #(.F(FRAC_BITS), .G(GAMMA_LUT_BITS), .ROW(1)) u_green (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (in_side_q),
    .lum_i  (lum_q),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .w_i    (w_q),
    .side_o (side_g),
    .gam_o  (gam_g)
  );

  cyg_chan #(.F(FRAC_BITS), .G(GAMMA_LUT_BITS), .ROW(2)) u_blue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .side_i (in_side_q),
    .lum_i  (lum_q),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .w_i    (w_q),
    .side_o (side_b),
    .gam_o  (gam_b)
  );

  assign done_o     = done_q;
  assign out_word_o = out_q;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_r.vld == side_g.vld) && (side_r.vld == side_b.vld))
    else $error("channel lanes out of step");

  a_never_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !((out_word_o.red == '0) && (out_word_o.green == '0)
                 && (out_word_o.blue == '0)))
    else $error("all-zero word delivered");

  a_bad_is_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_word_o.bad_chroma) |-> ((out_word_o.red == DarkCode)
      && (out_word_o.green == DarkCode) && (out_word_o.blue == DarkCode)))
    else $error("flagged word not dark");

endmodule

`default_nettype wire

>>> rtl/cyg_div.sv
// ----------------------------------------------------------------------------
// cyg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module cyg_div #(
  parameter int NB = 44,
  parameter int QB = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cyg_pkg::cyg_tag_t tag_i,
  input  logic [NB-1:0]     num_i,
  input  logic [13:0]       den_i,
  output cyg_pkg::cyg_tag_t tag_o,
  output logic [QB-1:0]     quo_o
);
  import cyg_pkg::*;

  cyg_tag_t      tag_q [QB];
  logic [NB-1:0] rem_q [QB];
  logic [13:0]   den_q [QB];
  logic [QB-1:0] quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    cyg_tag_t      tag_p;
    logic [NB-1:0] rem_p;
    logic [13:0]   den_p;
    logic [QB-1:0] quo_p;
    logic [NB-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign tag_p = tag_i;
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign tag_p = tag_q[k-1];
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {{(NB-14){1'b0}}, den_p} << (QB - 1 - k);
    assign ge    = (rem_p >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= tag_p;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[k] <= den_p;
      rem_q[k] <= ge ? (rem_p - trial) : rem_p;
      quo_q[k] <= quo_p | (ge ? (QB'(1) << (QB - 1 - k)) : '0);
    end
  end

  assign tag_o = tag_q[QB-1];
  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

>>> rtl/cyg_chan.sv
// ----------------------------------------------------------------------------
// cyg_chan
// one output channel: matrix row, scale by luminance, divide, clamp, gamma
// ----------------------------------------------------------------------------
`default_nettype none

module cyg_chan #(
  parameter int F   = 16,
  parameter int G   = 10,
  parameter int ROW = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cyg_pkg::cyg_side_t side_i,
  input  logic [13:0]        lum_i,
  input  logic [13:0]        cx_i,
  input  logic [13:0]        cy_i,
  input  logic signed [15:0] w_i,
  output cyg_pkg::cyg_side_t side_o,
  output logic [7:0]         gam_o
);
  import cyg_pkg::*;

  localparam int CB = F + 4;
  localparam int SB = CB + 18;
  localparam int TB = SB + 15;
  localparam int NB = F + 28;
  localparam int QB = F + 14;
  localparam int VB = G + 14;
  localparam int SH = VB + 14;
  localparam int RB = SH - 12;
  localparam int NE = (1 << G) + 1;
  localparam int IB = G + 1;
  localparam longint Recip = ((64'sd1 <<< SH) + 64'sd9999) / 64'sd10000;

  // row coefficients scaled by 2^F, rounded half away from zero
  localparam longint RowDen = longint'(MatDen[ROW]) * 64'sd1000;
  localparam longint N0 = longint'(MatNum[ROW * 3]);
  localparam longint N1 = longint'(MatNum[ROW * 3 + 1]);
  localparam longint N2 = longint'(MatNum[ROW * 3 + 2]);
  localparam longint A0 = (((N0 < 0) ? -N0 : N0) * 64'sd315) <<< F;
  localparam longint A1 = (((N1 < 0) ? -N1 : N1) * 64'sd315) <<< F;
  localparam longint A2 = (((N2 < 0) ? -N2 : N2) * 64'sd315) <<< F;
  localparam longint Q0 = (A0 + (RowDen >>> 1)) / RowDen;
  localparam longint Q1 = (A1 + (RowDen >>> 1)) / RowDen;
  localparam longint Q2 = (A2 + (RowDen >>> 1)) / RowDen;

  localparam logic signed [CB-1:0] C0 = CB'((N0 < 0) ? -Q0 : Q0);
  localparam logic signed [CB-1:0] C1 = CB'((N1 < 0) ? -Q1 : Q1);
  localparam logic signed [CB-1:0] C2 = CB'((N2 < 0) ? -Q2 : Q2);

  typedef logic [7:0] lut_t [NE];

  function automatic lut_t build_lut();
    lut_t t;
    for (int i = 0; i < NE; i++) t[i] = gamma_val(i, G);
    return t;
  endfunction

  localparam lut_t GammaLut = build_lut();

  // products
  cyg_side_t               s1_q;
  logic signed [CB+14:0]   p0_q, p1_q;
  logic signed [CB+15:0]   p2_q;
  logic [27:0]             lim1_q;
  logic [13:0]             lum1_q, cy1_q;
  // row sum
  cyg_side_t               s2_q;
  logic signed [SB-1:0]    sum_q;
  logic [27:0]             lim2_q;
  logic [13:0]             lum2_q, cy2_q;
  // luminance scale
  cyg_side_t               s3_q;
  logic signed [TB-1:0]    t_q;
  logic [27:0]             lim3_q;
  logic [13:0]             cy3_q;
  // clamp flags
  cyg_tag_t                g4_q;
  logic [NB-1:0]           num_q;
  logic [13:0]             cy4_q;
  // divider
  cyg_tag_t                dtag;
  logic [QB-1:0]           quo;
  logic [QB+G-1:0]         quo_sh;
  // index
  cyg_tag_t                g5_q, g6_q;
  logic [VB+RB-1:0]        prod_q;
  logic [IB-1:0]           idx_q;
  cyg_side_t               s7_q;
  logic [7:0]              gam_q;

  assign quo_sh = {quo, {G{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      g4_q <= '0;
      g5_q <= '0;
      g6_q <= '0;
      s7_q <= '0;
    end else begin
      s1_q <= side_i;
      s2_q <= s1_q;
      s3_q <= s2_q;
      g4_q <= '{side: s3_q,
                pos:  (t_q > 0),
                sat:  (t_q >= $signed({{(TB-NB){1'b0}}, lim3_q, {F{1'b0}}}))};
      g5_q <= dtag;
      g6_q <= g5_q;
      s7_q <= g6_q.side;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q   <= C0 * $signed({1'b0, cx_i});
    p1_q   <= C1 * $signed({1'b0, cy_i});
    p2_q   <= C2 * w_i;
    lim1_q <= 28'(cy_i) * 28'(WhiteSum);
    lum1_q <= lum_i;
    cy1_q  <= cy_i;

    sum_q  <= SB'(p0_q) + SB'(p1_q) + SB'(p2_q);
    lim2_q <= lim1_q;
    lum2_q <= lum1_q;
    cy2_q  <= cy1_q;

    t_q    <= sum_q * $signed({1'b0, lum2_q});
    lim3_q <= lim2_q;
    cy3_q  <= cy2_q;

    num_q  <= t_q[NB-1:0];
    cy4_q  <= cy3_q;

    prod_q <= quo_sh[F +: VB] * RB'(Recip);

    if (g5_q.side.kill || !g5_q.pos) begin
      idx_q <= '0;
    end else if (g5_q.sat) begin
      idx_q <= IB'(1) << G;
    end else begin
      idx_q <= {1'b0, prod_q[SH +: G]};
    end

    gam_q <= GammaLut[idx_q];
  end

  cyg_div #(
    .NB (NB),
    .QB (QB)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (g4_q),
    .num_i  (num_q),
    .den_i  (cy4_q),
    .tag_o  (dtag),
    .quo_o  (quo)
  );

  assign side_o = s7_q;
  assign gam_o  = gam_q;

endmodule

`default_nettype wire

>>> tb/cie_yxy_to_rgb_gamma_tb.sv
// ----------------------------------------------------------------------------
// cie_yxy_to_rgb_gamma_tb
// self-checking bench for the Yxy to gamma RGB converter: directed corner
// colours then random words, random sender gaps, one drain pause, and every
// result compared field by field against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cie_yxy_to_rgb_gamma_tb;
  import cyg_pkg::*;

  localparam int FracBits  = 16;
  localparam int LutBits   = 10;
  localparam int LutSize   = 1 << LutBits;
  localparam int Latency   = FracBits + 23;
  localparam int IdleLimit = 4000;
  localparam int NumRandom = 1950;

  typedef struct {
    cyg_in_t word;
    int      gap;
    bit      drain;
  } send_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  cyg_in_t  in_word_i = '0;
  logic     done_o;
  cyg_out_t out_word_o;

  send_t    send_q[$];
  cyg_out_t rgb_q[$];
  longint   coef_tab[9];
  logic [7:0] gamma_tab[LutSize + 1];
  int       errors = 0;
  int       words_in = 0;
  int       words_out = 0;
  int       idle_cycles = 0;
  int       gap_left = 0;
  bit       taken = 1'b0;

  cie_yxy_to_rgb_gamma #(
    .FRAC_BITS(FracBits),
    .GAMMA_LUT_BITS(LutBits)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .in_word_i(in_word_i),
    .done_o(done_o),
    .out_word_o(out_word_o)
  );

  always #2 clk_i = ~clk_i;

  // primaries and white point folded into one row-scaled matrix, plus the gamma table
  task automatic build_tables();
    int nums[9] = '{4674, -2126, -726, -2589, 5011, 111, 183, -617, 2883};
    int dens[3] = '{426, 858, 984};
    longint mag;
    longint den;
    logic [191:0] lhs;
    logic [191:0] rhs;
    int k;
    for (int i = 0; i < 9; i++) begin
      den = longint'(dens[i / 3]) * 1000;
      mag = longint'(nums[i] < 0 ? -nums[i] : nums[i]) * 315 * (64'sd1 << FracBits);
      coef_tab[i] = (mag + den / 2) / den;
      if (nums[i] < 0) coef_tab[i] = -coef_tab[i];
    end
    k = 0;
    for (int i = 0; i <= LutSize; i++) begin
      lhs = 192'(i) ** 5 * (192'd255 ** 11);
      while (k < 255) begin
        rhs = (192'(k + 1) ** 11) << (5 * LutBits);
        if (rhs <= lhs) k++;
        else break;
      end
      gamma_tab[i] = 8'(k);
    end
  endtask

  function automatic logic [7:0] linear_to_code(int row, longint lum, longint cx, longint cy);
    longint w;
    longint s;
    longint q;
    longint full;
    int idx;
    w = 10000 - cx - cy;
    s = coef_tab[row * 3] * cx + coef_tab[row * 3 + 1] * cy + coef_tab[row * 3 + 2] * w;
    q = (lum * s) / cy;
    full = longint'(10000) << FracBits;
    if (q <= 0) idx = 0;
    else if (q >= full) idx = LutSize;
    else idx = int'((q << LutBits) / full);
    return gamma_tab[idx];
  endfunction

  function automatic cyg_out_t predict_rgb(cyg_in_t w);
    cyg_out_t r;
    r = '0;
    if (w.chroma_y == 0) begin
      r.bad_chroma = (w.lum_y != 0);
    end else begin
      r.red   = linear_to_code(0, w.lum_y, w.chroma_x, w.chroma_y);
      r.green = linear_to_code(1, w.lum_y, w.chroma_x, w.chroma_y);
      r.blue  = linear_to_code(2, w.lum_y, w.chroma_x, w.chroma_y);
    end
    if (r.red == 0 && r.green == 0 && r.blue == 0) begin
      r.red   = 8'd7;
      r.green = 8'd7;
      r.blue  = 8'd7;
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, words_out);
    errors++;
  endtask

  task automatic queue_word(int lum, int cx, int cy, bit drain, bit no_gap);
    send_t s;
    s.word.lum_y    = 14'(lum);
    s.word.chroma_x = 14'(cx);
    s.word.chroma_y = 14'(cy);
    s.gap   = no_gap ? 0 : $urandom_range(0, 3);
    s.drain = drain;
    send_q.insert(send_q.size(), s);
  endtask

  // accept side, result checks and idle watchdog
  always @(posedge clk_i) begin
    cyg_out_t want;
    if (rst_ni && start && !busy) begin
      rgb_q.insert(rgb_q.size(), predict_rgb(in_word_i));
      words_in++;
    end
    taken <= rst_ni && start && !busy;
    if (rst_ni && done_o) begin
      if (rgb_q.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = rgb_q.pop_front();
        if (out_word_o.red !== want.red) report("red", out_word_o.red, want.red);
        if (out_word_o.green !== want.green) report("green", out_word_o.green, want.green);
        if (out_word_o.blue !== want.blue) report("blue", out_word_o.blue, want.blue);
        if (out_word_o.bad_chroma !== want.bad_chroma)
          report("bad_chroma", out_word_o.bad_chroma, want.bad_chroma);
      end
      words_out++;
    end
    if (rst_ni && !(start && !busy) && !done_o) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d words outstanding", rgb_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin
    logic nxt_start;
    cyg_in_t nxt_word;
    send_t s;
    nxt_start = start;
    nxt_word  = in_word_i;
    if (rst_ni && (!start || taken)) begin
      nxt_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (send_q.size() > 0 && (!send_q[0].drain || rgb_q.size() == 0)) begin
        s = send_q.pop_front();
        nxt_start = 1'b1;
        nxt_word  = s.word;
        gap_left  = s.gap;
      end
    end
    start     <= nxt_start;
    in_word_i <= nxt_word;
  end

  initial begin
    bit calm;
    int kind;
    build_tables();
    // directed corners
    queue_word(0, 3127, 3290, 0, 0);
    queue_word(5000, 3127, 0, 0, 0);
    queue_word(0, 0, 0, 0, 0);
    queue_word(10000, 3127, 3290, 0, 0);
    queue_word(16383, 3127, 3290, 0, 0);
    queue_word(10000, 6400, 3300, 0, 0);
    queue_word(10000, 2900, 6000, 0, 0);
    queue_word(10000, 1500, 600, 0, 0);
    queue_word(1, 3127, 3290, 0, 0);
    queue_word(2000, 0, 10000, 0, 0);
    queue_word(2000, 10000, 1, 0, 0);
    queue_word(2000, 7000, 6000, 0, 0);
    queue_word(16383, 16383, 16383, 0, 0);
    queue_word(16383, 0, 1, 0, 0);
    queue_word(16383, 16383, 1, 0, 0);
    queue_word(1, 0, 16383, 0, 0);
    queue_word(8000, 0, 1, 0, 0);
    queue_word(300, 4000, 4000, 0, 0);
    queue_word(16383, 5000, 0, 0, 0);
    calm = 1'b0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 97 == 0) calm = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6)
        queue_word($urandom_range(0, 10000), $urandom_range(0, 8000),
                   $urandom_range(1, 9000), i == NumRandom / 2, calm);
      else if (kind < 8)
        queue_word($urandom_range(0, 16383), $urandom_range(0, 16383),
                   $urandom_range(0, 16383), i == NumRandom / 2, calm);
      else if (kind < 9)
        queue_word($urandom_range(0, 200), $urandom_range(1000, 6000),
                   $urandom_range(1, 500), i == NumRandom / 2, calm);
      else
        queue_word($urandom_range(0, 16383), $urandom_range(0, 10000),
                   $urandom_range(0, 1), i == NumRandom / 2, calm);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (send_q.size() == 0 && !start && rgb_q.size() == 0);
    repeat (Latency + 20) @(posedge clk_i);
    $display("sent %0d words, checked %0d results: corner colours, out-of-range fields,",
             words_in, words_out);
    $display("zero luminance and zero chroma y, with random gaps and one drain pause");
    if (errors == 0 && rgb_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, rgb_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
